// ===== sv/array_insert_delete_search_top_macros.svh =====
// Assertion macros used by the checker file aids_chk.sv.
// All checks are clocked on clk_i and held off while rst_ni is low.
`ifndef ARRAY_INSERT_DELETE_SEARCH_TOP_MACROS_SVH
`define ARRAY_INSERT_DELETE_SEARCH_TOP_MACROS_SVH

// Same-cycle implication.
`define AIDS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define AIDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/aids_pkg.sv =====
// ----------------------------------------------------------------------------
// aids_pkg
// Shared types and constants for the array insert/delete/search block.
// ----------------------------------------------------------------------------
`default_nettype none

package aids_pkg;

  localparam int unsigned CAPACITY = 128;
  localparam int unsigned AddrW    = $clog2(CAPACITY);
  localparam int unsigned CntW     = $clog2(CAPACITY + 1);
  localparam int unsigned DataW    = 32;
  localparam int unsigned FuncW    = 3;
  localparam int unsigned PosW     = 8;
  localparam int unsigned StatW    = 2;
  localparam int unsigned FoundW   = 7;
  localparam int unsigned FillW    = 8;
  localparam int unsigned CmpW     = (CntW > PosW) ? CntW : PosW;

  typedef enum logic [FuncW-1:0] {
    OP_CLEAR  = 3'd0,
    OP_INSERT = 3'd1,
    OP_DELETE = 3'd2,
    OP_SEARCH = 3'd3,
    OP_READ   = 3'd4
  } func_e;

  typedef enum logic [StatW-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_MISS   = 2'd3
  } status_e;

  // Memory access bundle from the sequencer to the element RAM.
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [DataW-1:0] wdata;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

// ===== sv/aids_ram.sv =====
// ----------------------------------------------------------------------------
// aids_ram
// Element store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module aids_ram (
  input  wire logic                       clk_i,
  input  wire aids_pkg::mem_req_t         req_i,
  output logic [aids_pkg::DataW-1:0]      rdata_o
);
  import aids_pkg::*;

  logic [DataW-1:0] mem_q [CAPACITY];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/aids_seq.sv =====
// ----------------------------------------------------------------------------
// aids_seq
// Sequencer with one shared index adder and one word comparator; moves,
// scans and reads entries of the element RAM one step at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module aids_seq (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [aids_pkg::FuncW-1:0]  func_i,
  input  wire logic [aids_pkg::PosW-1:0]   position_i,
  input  wire logic [aids_pkg::DataW-1:0]  value_i,
  output logic                             busy_o,
  output logic                             done_o,
  output logic [aids_pkg::StatW-1:0]       status_o,
  output logic [aids_pkg::FoundW-1:0]      found_index_o,
  output logic [aids_pkg::DataW-1:0]       read_value_o,
  output logic [aids_pkg::FillW-1:0]       fill_count_o,
  output aids_pkg::mem_req_t               mem_req_o,
  input  wire logic [aids_pkg::DataW-1:0]  mem_rdata_i
);
  import aids_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_WR   = 4'b0100,
    S_PUT  = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic [CntW-1:0]  count_q, count_d;
  func_e            func_q, func_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [DataW-1:0] val_q, val_d;
  logic             done_q, done_d;
  status_e          status_q, status_d;
  logic [FoundW-1:0] found_q, found_d;
  logic [DataW-1:0] rdval_q, rdval_d;

  logic [CntW-1:0]  nb;       // shared adder: idx - 1 for insert, idx + 1 otherwise
  logic [CntW-1:0]  cnt_m1;
  logic             word_eq;  // word comparator for search
  logic [CmpW-1:0]  pos_ext, cnt_ext;

  assign nb      = (func_q == OP_INSERT) ? idx_q - CntW'(1) : idx_q + CntW'(1);
  assign cnt_m1  = count_q - CntW'(1);
  assign word_eq = (mem_rdata_i == val_q);
  assign pos_ext = CmpW'(position_i);
  assign cnt_ext = CmpW'(count_q);

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    count_d   = count_q;
    func_d    = func_q;
    pos_d     = pos_q;
    val_d     = val_q;
    done_d    = 1'b0;
    status_d  = status_q;
    found_d   = found_q;
    rdval_d   = rdval_q;
    mem_req_o = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          func_d   = func_e'(func_i);
          pos_d    = position_i;
          val_d    = value_i;
          status_d = ST_OK;
          found_d  = '0;
          rdval_d  = '0;
          unique case (func_e'(func_i))
            OP_CLEAR: begin
              count_d = '0;
              done_d  = 1'b1;
            end
            OP_INSERT: begin
              if (pos_ext > cnt_ext) begin
                status_d = ST_BADPOS;
                done_d   = 1'b1;
              end else if (cnt_ext >= CmpW'(CAPACITY)) begin
                status_d = ST_FULL;
                done_d   = 1'b1;
              end else if (pos_ext == cnt_ext) begin
                state_d = S_PUT;
              end else begin
                idx_d   = count_q;
                state_d = S_RD;
              end
            end
            OP_DELETE: begin
              if (pos_ext >= cnt_ext) begin
                status_d = ST_BADPOS;
                done_d   = 1'b1;
              end else if (pos_ext == CmpW'(cnt_m1)) begin
                // last entry: nothing to move
                count_d = cnt_m1;
                done_d  = 1'b1;
              end else begin
                idx_d   = CntW'(position_i);
                state_d = S_RD;
              end
            end
            OP_SEARCH: begin
              if (count_q == '0) begin
                status_d = ST_MISS;
                done_d   = 1'b1;
              end else begin
                idx_d   = '0;
                state_d = S_RD;
              end
            end
            OP_READ: begin
              if (pos_ext >= cnt_ext) begin
                status_d = ST_BADPOS;
                done_d   = 1'b1;
              end else begin
                idx_d   = CntW'(position_i);
                state_d = S_RD;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      S_RD: begin
        if ((func_q == OP_SEARCH) || (func_q == OP_READ)) begin
          mem_req_o.raddr = idx_q[AddrW-1:0];
        end else begin
          mem_req_o.raddr = nb[AddrW-1:0];
        end
        state_d = S_WR;
      end

      S_WR: begin
        case (func_q)
          OP_INSERT: begin
            mem_req_o.we    = 1'b1;
            mem_req_o.waddr = idx_q[AddrW-1:0];
            mem_req_o.wdata = mem_rdata_i;
            idx_d           = nb;
            state_d         = (CmpW'(nb) == CmpW'(pos_q)) ? S_PUT : S_RD;
          end
          OP_DELETE: begin
            mem_req_o.we    = 1'b1;
            mem_req_o.waddr = idx_q[AddrW-1:0];
            mem_req_o.wdata = mem_rdata_i;
            idx_d           = nb;
            if (nb == cnt_m1) begin
              count_d = cnt_m1;
              done_d  = 1'b1;
              state_d = S_IDLE;
            end else begin
              state_d = S_RD;
            end
          end
          OP_SEARCH: begin
            if (word_eq) begin
              found_d = FoundW'(idx_q);
              done_d  = 1'b1;
              state_d = S_IDLE;
            end else if (nb == count_q) begin
              status_d = ST_MISS;
              done_d   = 1'b1;
              state_d  = S_IDLE;
            end else begin
              idx_d   = nb;
              state_d = S_RD;
            end
          end
          default: begin
            // read
            rdval_d = mem_rdata_i;
            done_d  = 1'b1;
            state_d = S_IDLE;
          end
        endcase
      end

      S_PUT: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = pos_q[AddrW-1:0];
        mem_req_o.wdata = val_q;
        count_d         = count_q + CntW'(1);
        done_d          = 1'b1;
        state_d         = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      done_q   <= 1'b0;
      status_q <= ST_OK;
      found_q  <= '0;
      rdval_q  <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      done_q   <= done_d;
      status_q <= status_d;
      found_q  <= found_d;
      rdval_q  <= rdval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    func_q <= func_d;
    pos_q  <= pos_d;
    val_q  <= val_d;
  end

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign found_index_o = found_q;
  assign read_value_o  = rdval_q;
  assign fill_count_o  = FillW'(count_q);

endmodule

`default_nettype wire

// ===== sv/array_insert_delete_search_top.sv =====
// From transfer of a request to its result strobe: clear, unknown op, bad position, full
//   and delete of the last entry answer from idle; read passes S_RD, S_WR; insert at p with
//   n stored shifts p..n-1 up, S_PUT writes; delete shifts p+1..n-1 down; search scans up.
// A moved entry takes a RAM read and a RAM write step, a scanned one a read and a compare.
// busy drops with the strobe, so the next transfer may share its edge; no receiver stall.
// Reset empties the array (count 0); stored words are undefined until written.
// ----------------------------------------------------------------------------
// array_insert_delete_search_top
// Bounded ordered array of signed words with insert, delete, search and read.
// ----------------------------------------------------------------------------
`default_nettype none

module array_insert_delete_search_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [aids_pkg::FuncW-1:0]        func_i,
  input  wire logic [aids_pkg::PosW-1:0]         position_i,
  input  wire logic signed [aids_pkg::DataW-1:0] value_i,
  output logic                                   done_o,
  output logic [aids_pkg::StatW-1:0]             status_o,
  output logic [aids_pkg::FoundW-1:0]            found_index_o,
  output logic signed [aids_pkg::DataW-1:0]      read_value_o,
  output logic [aids_pkg::FillW-1:0]             fill_count_o
);
  import aids_pkg::*;

  mem_req_t         mem_req;
  logic [DataW-1:0] mem_rdata;
  logic [DataW-1:0] rd_word;

  aids_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .func_i        (func_i),
    .position_i    (position_i),
    .value_i       (value_i),
    .busy_o        (busy),
    .done_o        (done_o),
    .status_o      (status_o),
    .found_index_o (found_index_o),
    .read_value_o  (rd_word),
    .fill_count_o  (fill_count_o),
    .mem_req_o     (mem_req),
    .mem_rdata_i   (mem_rdata)
  );

  aids_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  assign read_value_o = signed'(rd_word);

endmodule

`default_nettype wire

// ===== sv/aids_chk.sv =====
// ----------------------------------------------------------------------------
// aids_chk
// Port-level checks for the array block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "array_insert_delete_search_top_macros.svh"

module aids_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [2:0]  func_i,
  input wire logic        done_o,
  input wire logic [1:0]  status_o,
  input wire logic [6:0]  found_index_o,
  input wire logic [31:0] read_value_o,
  input wire logic [7:0]  fill_count_o
);
  import aids_pkg::*;

  logic xfer;
  assign xfer = start && !busy;

  `AIDS_ASSERT_NOW(a_done_idle, done_o, !busy, "result strobe while busy")
  `AIDS_ASSERT_NOW(a_fail_zero, done_o && (status_o != ST_OK),
                   (found_index_o == '0) && (read_value_o == '0), "failed op with data")
  `AIDS_ASSERT_NEXT(a_clear, xfer && (func_i == OP_CLEAR),
                    done_o && (status_o == ST_OK) && (fill_count_o == '0), "clear result")
  `AIDS_ASSERT_NEXT(a_unknown, xfer && (func_i > OP_READ),
                    done_o && (status_o == ST_OK) && $stable(fill_count_o), "unknown op")

endmodule

bind array_insert_delete_search_top aids_chk u_aids_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .func_i        (func_i),
  .done_o        (done_o),
  .status_o      (status_o),
  .found_index_o (found_index_o),
  .read_value_o  (read_value_o),
  .fill_count_o  (fill_count_o)
);

`default_nettype wire

// ===== tb/tb_array_insert_delete_search_top.sv =====
// ----------------------------------------------------------------------------
// tb_array_insert_delete_search_top
// Self-checking bench for the ordered array block. Commands go in through the
// start/busy handshake from a queue. A shadow copy of the array predicts every
// result, and the monitor compares each done_o strobe against it field by
// field. A short directed opening is followed by fill-heavy and drain-heavy
// random phases under varying sender idle rates.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_array_insert_delete_search_top;
  timeunit 1ns;
  timeprecision 1ps;

  import aids_pkg::*;

  typedef struct {
    logic [FuncW-1:0]        func;
    logic [PosW-1:0]         pos;
    logic signed [DataW-1:0] val;
  } cmd_t;

  typedef struct {
    logic [StatW-1:0]        status;
    logic [FoundW-1:0]       found;
    logic signed [DataW-1:0] rdval;
    logic [FillW-1:0]        fill;
  } result_t;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    start         = 1'b0;
  logic [FuncW-1:0]        func_i        = '0;
  logic [PosW-1:0]         position_i    = '0;
  logic signed [DataW-1:0] value_i       = '0;
  logic                    busy;
  logic                    done_o;
  logic [StatW-1:0]        status_o;
  logic [FoundW-1:0]       found_index_o;
  logic signed [DataW-1:0] read_value_o;
  logic [FillW-1:0]        fill_count_o;

  cmd_t    pending_cmds[$];
  result_t expected_results[$];

  logic signed [DataW-1:0] elem_model [CAPACITY];
  int                      elem_count_model = 0;

  int idle_pct   = 0;
  int mismatches = 0;
  int errors     = 0;
  int gen_count  = 0;

  logic signed [DataW-1:0] value_pool [16];

  array_insert_delete_search_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .func_i        (func_i),
    .position_i    (position_i),
    .value_i       (value_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .found_index_o (found_index_o),
    .read_value_o  (read_value_o),
    .fill_count_o  (fill_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Apply one command to the shadow array and return what the block must answer.
  function automatic result_t predict_result(logic [FuncW-1:0] f, logic [PosW-1:0] p,
                                             logic signed [DataW-1:0] v);
    result_t r;
    int      k;
    r.status = ST_OK;
    r.found  = '0;
    r.rdval  = '0;
    case (f)
      OP_CLEAR: begin
        elem_count_model = 0;
      end
      OP_INSERT: begin
        if (int'(p) > elem_count_model) begin
          r.status = ST_BADPOS;
        end else if (elem_count_model >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (k = elem_count_model; k > int'(p); k--) elem_model[k] = elem_model[k-1];
          elem_model[p] = v;
          elem_count_model++;
        end
      end
      OP_DELETE: begin
        if (int'(p) >= elem_count_model) begin
          r.status = ST_BADPOS;
        end else begin
          for (k = int'(p); k + 1 < elem_count_model; k++) elem_model[k] = elem_model[k+1];
          elem_count_model--;
        end
      end
      OP_SEARCH: begin
        r.status = ST_MISS;
        for (k = 0; k < elem_count_model; k++) begin
          if (elem_model[k] == v) begin
            r.status = ST_OK;
            r.found  = k[FoundW-1:0];
            break;
          end
        end
      end
      OP_READ: begin
        if (int'(p) >= elem_count_model) r.status = ST_BADPOS;
        else r.rdval = elem_model[p];
      end
      default: begin
      end
    endcase
    r.fill = elem_count_model[FillW-1:0];
    return r;
  endfunction

  // Driver: hold the command until busy is low, then load the next one or idle.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) begin
        expected_results.push_back(predict_result(func_i, position_i, value_i));
        void'(pending_cmds.pop_front());
      end
      if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
        start      <= 1'b1;
        func_i     <= pending_cmds[0].func;
        position_i <= pending_cmds[0].pos;
        value_i    <= pending_cmds[0].val;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobe must match the oldest outstanding prediction.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("ERROR: result strobe with nothing outstanding, status %0d", status_o);
      end else begin
        result_t exp_r;
        exp_r = expected_results.pop_front();
        if (status_o !== exp_r.status || found_index_o !== exp_r.found ||
            read_value_o !== exp_r.rdval || fill_count_o !== exp_r.fill) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display(
              "MISMATCH: exp st=%0d idx=%0d rd=%0d fill=%0d, got st=%0d idx=%0d rd=%0d fill=%0d",
              exp_r.status, exp_r.found, exp_r.rdval, exp_r.fill,
              status_o, found_index_o, read_value_o, fill_count_o);
        end
      end
    end
  end

  // Queue a command and track the fill level so positions can be aimed.
  task automatic add_cmd(logic [FuncW-1:0] f, logic [PosW-1:0] p, logic signed [DataW-1:0] v);
    cmd_t c;
    c.func = f;
    c.pos  = p;
    c.val  = v;
    pending_cmds.push_back(c);
    case (f)
      OP_CLEAR:  gen_count = 0;
      OP_INSERT: if (int'(p) <= gen_count && gen_count < CAPACITY) gen_count++;
      OP_DELETE: if (int'(p) < gen_count) gen_count--;
      default: begin
      end
    endcase
  endtask

  function automatic logic signed [DataW-1:0] pick_value();
    if ($urandom_range(9) < 7) return value_pool[$urandom_range(15)];
    return $urandom;
  endfunction

  function automatic logic [PosW-1:0] pick_insert_pos();
    int r;
    r = $urandom_range(9);
    if (r < 2) return '0;
    if (r < 4) return gen_count[PosW-1:0];
    if (r == 4) return PosW'($urandom_range(255));
    return PosW'($urandom_range(gen_count, 0));
  endfunction

  function automatic logic [PosW-1:0] pick_index_pos();
    if ($urandom_range(9) == 0 || gen_count == 0) return PosW'($urandom_range(255));
    return PosW'($urandom_range(gen_count - 1, 0));
  endfunction

  task automatic wait_drain();
    do @(posedge clk_i);
    while (pending_cmds.size() != 0 || expected_results.size() != 0);
  endtask

  initial begin
    int ph;
    int n;
    int r;
    int ph_pct [4] = '{0, 46, 0, 36};

    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7fff_ffff;
    value_pool[2] = '0;
    value_pool[3] = -1;
    for (n = 4; n < 16; n++) value_pool[n] = $urandom;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening: empty array, bad positions, extremes, unknown ops.
    add_cmd(OP_READ,   8'd0,   '0);
    add_cmd(OP_DELETE, 8'd0,   '0);
    add_cmd(OP_SEARCH, 8'd0,   '0);
    add_cmd(OP_INSERT, 8'd1,   32'sd5);
    add_cmd(OP_INSERT, 8'd0,   32'sh8000_0000);
    add_cmd(OP_INSERT, 8'd1,   32'sh7fff_ffff);
    add_cmd(OP_INSERT, 8'd0,   -32'sd1);
    add_cmd(OP_INSERT, 8'd3,   '0);
    add_cmd(OP_READ,   8'd0,   '0);
    add_cmd(OP_READ,   8'd3,   '0);
    add_cmd(OP_READ,   8'd4,   '0);
    add_cmd(OP_SEARCH, 8'd0,   32'sh7fff_ffff);
    add_cmd(OP_SEARCH, 8'd0,   '0);
    add_cmd(OP_SEARCH, 8'd0,   32'sd12345);
    add_cmd(OP_INSERT, 8'd255, 32'sd9);
    add_cmd(OP_READ,   8'd128, '0);
    add_cmd(OP_DELETE, 8'd3,   '0);
    add_cmd(OP_DELETE, 8'd0,   '0);
    add_cmd(OP_DELETE, 8'd5,   '0);
    add_cmd(3'd5,      8'd0,   $urandom);
    add_cmd(3'd6,      PosW'($urandom_range(255)), $urandom);
    add_cmd(3'd7,      8'd1,   $urandom);
    add_cmd(OP_INSERT, 8'd2,   32'sh7fff_ffff);
    add_cmd(OP_SEARCH, 8'd0,   32'sh7fff_ffff);
    add_cmd(OP_CLEAR,  8'd0,   '0);
    add_cmd(OP_READ,   8'd0,   '0);
    wait_drain();

    // Random phases: even ones grow the array toward full, odd ones shrink it.
    for (ph = 0; ph < 8; ph++) begin
      idle_pct = ph_pct[ph % 4];
      for (n = 0; n < 200; n++) begin
        r = $urandom_range(99);
        if (ph % 2 == 0) begin
          if (r < 78)      add_cmd(OP_INSERT, pick_insert_pos(), pick_value());
          else if (r < 84) add_cmd(OP_DELETE, pick_index_pos(), $urandom);
          else if (r < 92) add_cmd(OP_SEARCH, PosW'($urandom_range(255)), pick_value());
          else if (r < 98) add_cmd(OP_READ, pick_index_pos(), $urandom);
          else             add_cmd(FuncW'($urandom_range(7, 5)),
                                   PosW'($urandom_range(255)), $urandom);
        end else begin
          if (r < 1)       add_cmd(OP_CLEAR, PosW'($urandom_range(255)), $urandom);
          else if (r < 25) add_cmd(OP_INSERT, pick_insert_pos(), pick_value());
          else if (r < 60) add_cmd(OP_DELETE, pick_index_pos(), $urandom);
          else if (r < 78) add_cmd(OP_SEARCH, PosW'($urandom_range(255)), pick_value());
          else if (r < 96) add_cmd(OP_READ, pick_index_pos(), $urandom);
          else             add_cmd(FuncW'($urandom_range(7, 5)),
                                   PosW'($urandom_range(255)), $urandom);
        end
      end
      wait_drain();
    end

    // Let any stray strobe show up before the verdict.
    repeat (300) @(posedge clk_i);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+sv
sv/aids_pkg.sv
sv/aids_ram.sv
sv/aids_seq.sv
sv/array_insert_delete_search_top.sv
sv/aids_chk.sv
tb/tb_array_insert_delete_search_top.sv
